// ===== rtl/core/itc_pkg.sv =====
// itc_pkg: shared constants, codes and controller/datapath link types
// for the interval table classifier; no dependencies
package itc_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CFG_W           = 9;
  localparam int SLOT_W          = 8;
  localparam int CLASS_W         = 8;

  // item command codes
  typedef enum logic [0:0] {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } itc_cmd_code_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_END_A,
    S_END_B,
    S_RESULT
  } itc_state_t;

  // table read address select
  typedef enum logic [2:0] {
    RD_HOLD,
    RD_INIT_MID,
    RD_INIT_A,
    RD_STEP_MID,
    RD_STEP_A,
    RD_B
  } itc_rd_sel_t;

  typedef struct packed {
    logic        write_entry;
    logic        ab_init;
    logic        ab_step;
    logic        res_clear;
    logic        res_load;
    logic        out_load;
    itc_rd_sel_t rd_sel;
  } itc_cmd_t;

  typedef struct packed {
    logic is_write;
    logic n_zero;
    logic init_narrow;
    logic match;
    logic next_narrow;
    logic ends_differ;
    logic out_free;
  } itc_status_t;

endpackage

// ===== rtl/core/itc_ifs.sv =====
// itc_ifs: valid/ready channel interfaces for items, results and the
// entries_in_use register; depends on itc_pkg
interface itc_item_if import itc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [SLOT_W-1:0]             slot;
  logic signed [VALUE_WIDTH-1:0] lower_bound;
  logic signed [VALUE_WIDTH-1:0] upper_bound;
  logic [CLASS_W-1:0]            class_number;
  logic signed [VALUE_WIDTH-1:0] sample_value;

  modport source (
    output valid, command, slot, lower_bound, upper_bound, class_number, sample_value,
    input  ready
  );
  modport sink (
    input  valid, command, slot, lower_bound, upper_bound, class_number, sample_value,
    output ready
  );
endinterface

interface itc_result_if import itc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               found;
  logic [CLASS_W-1:0] matched_class;

  modport source (output valid, found, matched_class, input ready);
  modport sink (input valid, found, matched_class, output ready);
endinterface

interface itc_cfg_if import itc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink (input valid, entries_in_use, output ready);
endinterface

// ===== rtl/core/itc_ctrl.sv =====
// itc_ctrl: sequencer for writes, binary search probes and end checks
// depends on itc_pkg
module itc_ctrl import itc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  itc_status_t status,
  output itc_cmd_t    cmd
);

  itc_state_t state;
  itc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.is_write || status.n_zero) begin
            state_next = S_RESULT;
          end else if (status.init_narrow) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_END_A;
          end
        end
      end
      S_SEARCH: begin
        if (status.match) begin
          state_next = S_RESULT;
        end else if (status.next_narrow) begin
          state_next = S_SEARCH;
        end else begin
          state_next = S_END_A;
        end
      end
      S_END_A: begin
        if (!status.match && status.ends_differ) begin
          state_next = S_END_B;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_END_B: state_next = S_RESULT;
      S_RESULT: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_HOLD;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.is_write) begin
            cmd.write_entry = 1'b1;
            cmd.res_clear   = 1'b1;
          end else begin
            cmd.ab_init = 1'b1;
            if (status.n_zero) begin
              cmd.res_clear = 1'b1;
            end else if (status.init_narrow) begin
              cmd.rd_sel = RD_INIT_MID;
            end else begin
              cmd.rd_sel = RD_INIT_A;
            end
          end
        end
      end
      S_SEARCH: begin
        if (status.match) begin
          cmd.res_load = 1'b1;
        end else begin
          cmd.ab_step = 1'b1;
          cmd.rd_sel  = status.next_narrow ? RD_STEP_MID : RD_STEP_A;
        end
      end
      S_END_A: begin
        if (!status.match && status.ends_differ) begin
          cmd.rd_sel = RD_B;
        end else begin
          cmd.res_load = 1'b1;
        end
      end
      S_END_B: cmd.res_load = 1'b1;
      S_RESULT: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/itc_dp.sv =====
// itc_dp: entry memories, search bounds, entry compare and output register
// depends on itc_pkg
module itc_dp import itc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  itc_cmd_t                      cmd,
  output itc_status_t                   status,
  input  logic                          command,
  input  logic [SLOT_W-1:0]             slot,
  input  logic signed [VALUE_WIDTH-1:0] lower_bound,
  input  logic signed [VALUE_WIDTH-1:0] upper_bound,
  input  logic [CLASS_W-1:0]            class_number,
  input  logic signed [VALUE_WIDTH-1:0] sample_value,
  input  logic                          cfg_wr,
  input  logic [CFG_W-1:0]              cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [CLASS_W-1:0]            matched_class
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [VALUE_WIDTH-1:0] lo_mem  [TABLE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] hi_mem  [TABLE_DEPTH];
  logic [CLASS_W-1:0]            cls_mem [TABLE_DEPTH];

  logic [CFG_W-1:0]              entries_in_use;
  logic signed [VALUE_WIDTH-1:0] sample;
  logic [IW-1:0]                 a;
  logic [IW-1:0]                 b;
  logic [IW-1:0]                 last_idx;
  logic [IW-1:0]                 rd_idx;
  logic signed [VALUE_WIDTH-1:0] rd_lo;
  logic signed [VALUE_WIDTH-1:0] rd_hi;
  logic [CLASS_W-1:0]            rd_cls;
  logic                          res_found;
  logic [CLASS_W-1:0]            res_class;

  logic [CW-1:0] n_eff;
  logic [IW-1:0] last_init;
  logic [IW-1:0] a_step;
  logic [IW-1:0] b_step;
  logic [IW-1:0] mid_step;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic          eq_lo, lt_lo, inv, lt_hi, eq_hi, match, below;

  // count clamped to the table depth
  always_comb begin
    if (int'(entries_in_use) > TABLE_DEPTH) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = CW'(entries_in_use);
    end
    last_init = IW'(n_eff - CW'(1));
  end

  // entry compare against the word read last cycle
  always_comb begin
    eq_lo = (sample == rd_lo);
    lt_lo = (sample < rd_lo);
    inv   = (rd_hi < rd_lo);
    lt_hi = (sample < rd_hi);
    eq_hi = (sample == rd_hi);
    match = eq_lo || (!lt_lo && !inv && (lt_hi || ((rd_idx == last_idx) && eq_hi)));
    below = !eq_lo && lt_lo;
  end

  // next search bounds, rd_idx is the probed midpoint
  always_comb begin
    a_step = a;
    b_step = b;
    if (below) begin
      b_step = (b > rd_idx) ? rd_idx : b - IW'(1);
    end else begin
      a_step = (a < rd_idx) ? rd_idx : a + IW'(1);
    end
    mid_step = a_step + ((b_step - a_step) >> 1);
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_INIT_MID: rd_addr = last_init >> 1;
      RD_INIT_A:   rd_addr = '0;
      RD_STEP_MID: rd_addr = mid_step;
      RD_STEP_A:   rd_addr = a_step;
      RD_B:        rd_addr = b;
      default:     rd_addr = rd_idx;
    endcase
  end

  assign wr_en = cmd.write_entry && (int'(slot) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo_mem[IW'(slot)]  <= lower_bound;
      hi_mem[IW'(slot)]  <= upper_bound;
      cls_mem[IW'(slot)] <= class_number;
    end
    rd_lo  <= lo_mem[rd_addr];
    rd_hi  <= hi_mem[rd_addr];
    rd_cls <= cls_mem[rd_addr];
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_wr) begin
      entries_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ab_init) begin
      sample   <= sample_value;
      a        <= '0;
      b        <= last_init;
      last_idx <= last_init;
    end else if (cmd.ab_step) begin
      a <= a_step;
      b <= b_step;
    end
    if (cmd.res_clear) begin
      res_found <= 1'b0;
      res_class <= '0;
    end else if (cmd.res_load) begin
      res_found <= match;
      res_class <= match ? rd_cls : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found         <= res_found;
      matched_class <= res_class;
    end
  end

  always_comb begin
    status.is_write    = (command == CMD_WRITE);
    status.n_zero      = (n_eff == '0);
    status.init_narrow = (last_init != '0);
    status.match       = match;
    status.next_narrow = (a_step < b_step);
    status.ends_differ = (a != b);
    status.out_free    = !out_valid || out_ready;
  end

endmodule

// ===== rtl/core/interval_table_classifier.sv =====
// interval_table_classifier: top level, controller plus datapath
// depends on itc_pkg, itc_ifs, itc_ctrl and itc_dp
//
// classifies signed fixed point words against a table of intervals kept in
// ascending order of lower bound. a write word stores lower bound, upper
// bound and class number at its slot (slots at or past TABLE_DEPTH are
// dropped) and returns one word with found = 0. a lookup word runs a binary
// search over the first entries_in_use entries, then checks the entries
// left at the two ends of the search range, and returns found with the
// class number, or found = 0 and class 0. entries must be written in
// sorted order and before they are searched; the block does not sort. a
// word is accepted in the idle state; a write then goes to the result
// step, a lookup runs its search probes, the end checks and the result
// step. a probe that matches skips the rest of the search and the end
// checks. the search is paced by the single read port of the entry
// memory, which serves one probe per cycle. the block takes one word at a
// time; the finished result sits in an output register, so the next word
// is accepted while the previous result waits. entries_in_use may be
// written at any time the block is idle; its write channel is always ready.
module interval_table_classifier import itc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  itc_item_if.sink     item,
  itc_result_if.source result,
  itc_cfg_if.sink      cfg
);

  itc_cmd_t    cmd;
  itc_status_t status;
  logic        in_ready;

  // the register port never stalls
  assign cfg.ready  = 1'b1;
  assign item.ready = in_ready;

  // sequencer: idle, search probes, end checks, result hand-off
  itc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // entry memories, bound registers, compare and output register
  itc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .command       (item.command),
    .slot          (item.slot),
    .lower_bound   (item.lower_bound),
    .upper_bound   (item.upper_bound),
    .class_number  (item.class_number),
    .sample_value  (item.sample_value),
    .cfg_wr        (cfg.valid),
    .cfg_data      (cfg.entries_in_use),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .found         (result.found),
    .matched_class (result.matched_class)
  );

endmodule
